// ----- hw/rtl/polynomial_substring_hash_defines.svh -----
// Assertion macros shared by the substring hash RTL.
// Expects signals named clk and arst_n in the scope of each use.
// Assertions are compiled out when SYNTH is defined.
`ifndef POLYNOMIAL_SUBSTRING_HASH_DEFINES_SVH
`define POLYNOMIAL_SUBSTRING_HASH_DEFINES_SVH

`ifndef SYNTH
// Check that a property holds at every clock edge out of reset.
`define PSH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check that a condition never occurs at any clock edge out of reset.
`define PSH_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define PSH_ASSERT(lbl, prop, msg)
`define PSH_NEVER(lbl, cond, msg)
`endif

`endif

// ----- hw/rtl/psh_pkg.sv -----
// Shared types and constants of the polynomial substring hash.
// No dependencies; the interfaces and all modules but psh_ram use it.
package psh_pkg;

	// field widths
	localparam int ActW  = 2;
	localparam int CharW = 7;
	localparam int IdxW  = 10;
	localparam int HashW = 30;

	// modular arithmetic constants
	localparam logic [HashW-1:0] HashMod  = 30'd1000000007;
	localparam logic [HashW-1:0] HashBase = 30'd31;
	// 31 * InvBase == 1 mod HashMod
	localparam logic [HashW-1:0] InvBase  = 30'd129032259;
	// Barrett reduction: mu = floor(2^(2*HashW) / HashMod)
	localparam int BarrettW = HashW + 1;
	localparam logic [BarrettW-1:0] BarrettMu =
		BarrettW'((64'd1 << (2 * HashW)) / 64'(HashMod));
	// character code that maps to digit zero ('a' - 1)
	localparam logic [CharW-1:0] CharBias = 7'd96;

	// input actions
	typedef enum logic [ActW-1:0] {
		ACT_APPEND = 2'd0,
		ACT_QUERY  = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	// classified operations passed from front end to back end
	typedef enum logic [1:0] {
		OP_APPEND,
		OP_QUERY,
		OP_ERROR,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [CharW-1:0] char_code;
		logic [IdxW-1:0]  left_index;
		logic [IdxW-1:0]  right_index;
	} cmd_t;

endpackage

// ----- hw/rtl/psh_in_if.sv -----
// Input word channel of the substring hash: valid/ready plus command fields.
// Depends on psh_pkg for field widths.
interface psh_in_if;
	logic                         valid;
	logic                         ready;
	logic [psh_pkg::ActW-1:0]     action;
	logic [psh_pkg::CharW-1:0]    char_code;
	logic [psh_pkg::IdxW-1:0]     left_index;
	logic [psh_pkg::IdxW-1:0]     right_index;

	modport source (output valid, action, char_code, left_index, right_index, input ready);
	modport sink (input valid, action, char_code, left_index, right_index, output ready);
endinterface

// ----- hw/rtl/psh_out_if.sv -----
// Result word channel of the substring hash: valid/ready plus hash and error.
// Depends on psh_pkg for field widths.
interface psh_out_if;
	logic                       valid;
	logic                       ready;
	logic [psh_pkg::HashW-1:0]  hash_value;
	logic                       error;

	modport source (output valid, hash_value, error, input ready);
	modport sink (input valid, hash_value, error, output ready);
endinterface

// ----- hw/rtl/polynomial_substring_hash.sv -----
// Polynomial substring hash (prefix hash mod 1e9+7, base 31).
// Input words on cmd: action 0 appends char_code, 1 queries the hash of
// positions left_index..right_index, 2 clears the string, 3 is ignored.
// Each query gives one result word on res: the hash normalized to start at
// power 31^0, or error set and hash zero when the range is bad. Appends past
// MAX_LEN are dropped. No other action gives a result.
// The back end works on one queued operation at a time: appends and valid
// queries wait on the five-stage modular multiplier, bad queries go straight
// to the result state and clears finish in the idle state.
// A four-entry queue parts the front end from the back end, and a result
// register holds a finished word, so input words keep being accepted while
// the receiver stalls until the queue fills; cmd.ready then drops.
// Reset empties the queue and the result register and restarts the string
// at length zero; the stores need no clearing.
// Depends on psh_pkg, psh_in_if, psh_out_if, psh_front, psh_fifo, psh_back.
module polynomial_substring_hash #(
	parameter int MAX_LEN     = 1024,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	psh_in_if.sink     cmd,
	psh_out_if.source  res
);

	logic           q_push, q_full, q_pop, q_empty;
	psh_pkg::cmd_t  q_data, q_head;

	psh_front #(.MAX_LEN(MAX_LEN)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.q_push (q_push),
		.q_data (q_data),
		.q_full (q_full)
	);

	psh_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty),
		.full      (q_full)
	);

	psh_back #(.MAX_LEN(MAX_LEN)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_head  (q_head),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.res     (res)
	);

endmodule

// ----- hw/rtl/psh_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psh_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/psh_modmul.sv -----
// Pipelined modular multiplier, a * b mod HashMod, by Barrett reduction.
// Five stages, one issue per cycle. Depends on psh_pkg.
module psh_modmul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [psh_pkg::HashW-1:0]  a,
	input  logic [psh_pkg::HashW-1:0]  b,
	output logic                       out_valid,
	output logic [psh_pkg::HashW-1:0]  result
);

	localparam int HW = psh_pkg::HashW;
	localparam int PW = 2 * HW;
	localparam int RW = HW + 2;
	localparam int QW = PW + 2;

	logic [PW-1:0] prod_s1;
	logic [HW-1:0] q_s2;
	logic [RW-1:0] plo_s2, plo_s3, qm_s3, r_s4;
	logic [HW-1:0] res_s5;
	logic [4:0]    v_q;
	logic [QW-1:0] q_wide;
	logic [RW-1:0] mod1, mod2;

	assign q_wide = QW'(prod_s1[PW-1:HW-1]) * QW'(psh_pkg::BarrettMu);
	assign mod1   = RW'(psh_pkg::HashMod);
	assign mod2   = RW'(psh_pkg::HashMod) << 1;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[3:0], in_valid};
		end
	end

	// product, quotient estimate, remainder, final correction
	always_ff @(posedge clk) begin
		prod_s1 <= PW'(a) * PW'(b);
		q_s2    <= q_wide[PW:HW+1];
		plo_s2  <= prod_s1[RW-1:0];
		qm_s3   <= RW'(PW'(q_s2) * PW'(psh_pkg::HashMod));
		plo_s3  <= plo_s2;
		r_s4    <= plo_s3 - qm_s3;
		if (r_s4 >= mod2) begin
			res_s5 <= HW'(r_s4 - mod2);
		end else if (r_s4 >= mod1) begin
			res_s5 <= HW'(r_s4 - mod1);
		end else begin
			res_s5 <= r_s4[HW-1:0];
		end
	end

	assign out_valid = v_q[4];
	assign result    = res_s5;

endmodule

// ----- hw/rtl/psh_fifo.sv -----
// Short command queue between the front end and the back end.
// Depends on psh_pkg for the command struct.
`include "polynomial_substring_hash_defines.svh"

module psh_fifo #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  psh_pkg::cmd_t  push_data,
	input  logic           pop,
	output psh_pkg::cmd_t  head,
	output logic           empty,
	output logic           full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	psh_pkg::cmd_t  mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		next_ptr = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign empty = (count_q == '0);
	assign full  = (count_q == CW'(DEPTH));
	assign head  = mem_q[rd_ptr_q];

	// hold entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`PSH_NEVER(a_no_overflow, push && full, "command pushed into full queue")
	`PSH_NEVER(a_no_underflow, pop && empty, "command popped from empty queue")
	`PSH_ASSERT(a_count_up, push && !pop |=> count_q == $past(count_q) + 1'b1, "queue count did not advance")

endmodule

// ----- hw/rtl/psh_front.sv -----
// Front end: accepts input words, tracks the stored length, classifies each
// word into a queued operation or drops it. Depends on psh_pkg and psh_in_if.
module psh_front #(
	parameter int MAX_LEN = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	psh_in_if.sink         cmd,
	output logic           q_push,
	output psh_pkg::cmd_t  q_data,
	input  logic           q_full
);

	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int CW = (LW > psh_pkg::IdxW) ? LW : psh_pkg::IdxW;

	logic [LW-1:0] len_q;
	logic          accept, len_full, range_bad;

	assign cmd.ready = !q_full;
	assign accept    = cmd.valid && cmd.ready;
	assign len_full  = (len_q == LW'(MAX_LEN));
	assign range_bad = (cmd.left_index > cmd.right_index) ||
		(CW'(cmd.right_index) >= CW'(len_q));

	// classify the word; drop appends to a full store and unused actions
	always_comb begin
		q_data.char_code   = cmd.char_code;
		q_data.left_index  = cmd.left_index;
		q_data.right_index = cmd.right_index;
		q_data.op          = psh_pkg::OP_CLEAR;
		q_push             = 1'b0;
		case (cmd.action)
			psh_pkg::ACT_APPEND: begin
				q_data.op = psh_pkg::OP_APPEND;
				q_push    = accept && !len_full;
			end
			psh_pkg::ACT_QUERY: begin
				q_data.op = range_bad ? psh_pkg::OP_ERROR : psh_pkg::OP_QUERY;
				q_push    = accept;
			end
			psh_pkg::ACT_CLEAR: begin
				q_data.op = psh_pkg::OP_CLEAR;
				q_push    = accept;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	// track stored length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (accept) begin
			if (cmd.action == psh_pkg::ACT_APPEND && !len_full) begin
				len_q <= len_q + 1'b1;
			end else if (cmd.action == psh_pkg::ACT_CLEAR) begin
				len_q <= '0;
			end
		end
	end

endmodule

// ----- hw/rtl/psh_back.sv -----
// Back end: executes queued operations against the prefix and inverse power
// stores using the shared modular multiplier, and holds the result register.
// Depends on psh_pkg, psh_out_if, psh_ram and psh_modmul.
`include "polynomial_substring_hash_defines.svh"

module psh_back #(
	parameter int MAX_LEN = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  psh_pkg::cmd_t  q_head,
	input  logic           q_empty,
	output logic           q_pop,
	psh_out_if.source      res
);

	localparam int HW = psh_pkg::HashW;
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_APP1,
		ST_APP2,
		ST_APP_WAIT,
		ST_Q_READ2,
		ST_Q_DIFF,
		ST_Q_MUL,
		ST_Q_WAIT,
		ST_RESULT
	} state_t;

	state_t         state_q;
	psh_pkg::cmd_t  cmd_q;
	logic [HW-1:0]  hash_q, power_q, invp_q;
	logic [AW-1:0]  pos_q;
	logic [1:0]     res_cnt_q;
	logic [HW-1:0]  hi_q, inv_q, diff_q, rhash_q, res_hash_q;
	logic           rerr_q, res_valid_q, res_err_q;

	logic           start, load_res;
	logic [HW-1:0]  digit, hash_sum, lo, diff_w;
	logic [HW:0]    sum_w;
	logic           mul_valid, mulr_valid;
	logic [HW-1:0]  mul_a, mul_b, mulr_value;
	logic           pre_we, inv_we;
	logic [AW-1:0]  pre_raddr, inv_raddr;
	logic [HW-1:0]  pre_rdata, inv_rdata;

	assign start    = (state_q == ST_IDLE) && !q_empty;
	assign q_pop    = start;
	assign load_res = (state_q == ST_RESULT) && (!res_valid_q || res.ready);

	// digit of the head character, wrapped mod HashMod below 'a' - 1
	always_comb begin
		if (q_head.char_code >= psh_pkg::CharBias) begin
			digit = HW'(q_head.char_code - psh_pkg::CharBias);
		end else begin
			digit = psh_pkg::HashMod - HW'(psh_pkg::CharBias - q_head.char_code);
		end
	end

	// running hash plus new term, reduced once
	assign sum_w    = {1'b0, hash_q} + {1'b0, mulr_value};
	assign hash_sum = (sum_w >= (HW + 1)'(psh_pkg::HashMod)) ?
		HW'(sum_w - (HW + 1)'(psh_pkg::HashMod)) : sum_w[HW-1:0];

	// prefix difference brought into range
	assign lo     = (cmd_q.left_index == '0) ? '0 : pre_rdata;
	assign diff_w = (hi_q >= lo) ? hi_q - lo : hi_q + (psh_pkg::HashMod - lo);

	// select multiplier operands
	always_comb begin
		mul_valid = 1'b0;
		mul_a     = digit;
		mul_b     = power_q;
		case (state_q)
			ST_IDLE: begin
				mul_valid = start && (q_head.op == psh_pkg::OP_APPEND);
			end
			ST_APP1: begin
				mul_valid = 1'b1;
				mul_a     = power_q;
				mul_b     = psh_pkg::HashBase;
			end
			ST_APP2: begin
				mul_valid = 1'b1;
				mul_a     = invp_q;
				mul_b     = psh_pkg::InvBase;
			end
			ST_Q_MUL: begin
				mul_valid = 1'b1;
				mul_a     = diff_q;
				mul_b     = inv_q;
			end
			default: begin
				mul_valid = 1'b0;
			end
		endcase
	end

	// store ports
	assign inv_we    = start && (q_head.op == psh_pkg::OP_APPEND);
	assign inv_raddr = AW'(q_head.left_index);
	assign pre_we    = (state_q == ST_APP_WAIT) && mulr_valid && (res_cnt_q == 2'd0);
	assign pre_raddr = (state_q == ST_Q_READ2) ? AW'(cmd_q.left_index - 1'b1) :
		AW'(q_head.right_index);

	psh_ram #(.WIDTH(HW), .DEPTH(MAX_LEN)) u_prefix_ram (
		.clk   (clk),
		.we    (pre_we),
		.waddr (pos_q),
		.wdata (hash_sum),
		.raddr (pre_raddr),
		.rdata (pre_rdata)
	);

	psh_ram #(.WIDTH(HW), .DEPTH(MAX_LEN)) u_invpow_ram (
		.clk   (clk),
		.we    (inv_we),
		.waddr (pos_q),
		.wdata (invp_q),
		.raddr (inv_raddr),
		.rdata (inv_rdata)
	);

	psh_modmul u_modmul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mul_valid),
		.a         (mul_a),
		.b         (mul_b),
		.out_valid (mulr_valid),
		.result    (mulr_value)
	);

	// sequencer, running state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= '0;
			hash_q      <= '0;
			power_q     <= HW'(1);
			invp_q      <= HW'(1);
			pos_q       <= '0;
			res_cnt_q   <= '0;
			hi_q        <= '0;
			inv_q       <= '0;
			diff_q      <= '0;
			rhash_q     <= '0;
			rerr_q      <= 1'b0;
			res_valid_q <= 1'b0;
			res_hash_q  <= '0;
			res_err_q   <= 1'b0;
		end else begin
			if (res_valid_q && res.ready && !load_res) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q <= q_head;
						case (q_head.op)
							psh_pkg::OP_APPEND: begin
								res_cnt_q <= '0;
								state_q   <= ST_APP1;
							end
							psh_pkg::OP_QUERY: begin
								state_q <= ST_Q_READ2;
							end
							psh_pkg::OP_ERROR: begin
								rhash_q <= '0;
								rerr_q  <= 1'b1;
								state_q <= ST_RESULT;
							end
							psh_pkg::OP_CLEAR: begin
								hash_q  <= '0;
								power_q <= HW'(1);
								invp_q  <= HW'(1);
								pos_q   <= '0;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_APP1: begin
					state_q <= ST_APP2;
				end
				ST_APP2: begin
					state_q <= ST_APP_WAIT;
				end
				ST_APP_WAIT: begin
					if (mulr_valid) begin
						res_cnt_q <= res_cnt_q + 1'b1;
						case (res_cnt_q)
							2'd0: begin
								hash_q <= hash_sum;
							end
							2'd1: begin
								power_q <= mulr_value;
							end
							default: begin
								invp_q  <= mulr_value;
								pos_q   <= pos_q + 1'b1;
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_Q_READ2: begin
					hi_q    <= pre_rdata;
					inv_q   <= inv_rdata;
					state_q <= ST_Q_DIFF;
				end
				ST_Q_DIFF: begin
					diff_q  <= diff_w;
					state_q <= ST_Q_MUL;
				end
				ST_Q_MUL: begin
					state_q <= ST_Q_WAIT;
				end
				ST_Q_WAIT: begin
					if (mulr_valid) begin
						rhash_q <= mulr_value;
						rerr_q  <= 1'b0;
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (load_res) begin
						res_valid_q <= 1'b1;
						res_hash_q  <= rhash_q;
						res_err_q   <= rerr_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res.valid      = res_valid_q;
	assign res.hash_value = res_hash_q;
	assign res.error      = res_err_q;

	`PSH_ASSERT(a_mul_in_wait, mulr_valid |-> (state_q == ST_APP_WAIT || state_q == ST_Q_WAIT), "multiplier result outside a wait state")
	`PSH_ASSERT(a_error_zero, res.valid && res.error |-> res.hash_value == '0, "error result with nonzero hash")
	`PSH_ASSERT(a_hash_range, res.valid |-> res.hash_value < psh_pkg::HashMod, "result hash not reduced")

endmodule
